[src/tfn_pkg.sv]
// Triangle face normal: shared types and fixed-width constants.
// No dependencies; imported by every module of the block.
`default_nettype none
package tfn_pkg;

  localparam int TAG_W   = 16;  // face tag width
  localparam int KEEP_W  = 30;  // magnitude bits kept after normalization shift
  localparam int SQ_W    = 2 * KEEP_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = 31;  // floor(sqrt(sum)) fits in 31 bits
  localparam int RES_W   = 2 * ROOT_W + 1;
  localparam int FRAC_Q  = 14;  // Q1.14 output
  localparam int Q_W     = FRAC_Q + 1;
  localparam int NUM_W   = KEEP_W + FRAC_Q + 2;
  localparam int OUT_W   = 16;
  localparam int ONE_Q14 = 16384;

  // Stage counts of each pipeline section
  localparam int CROSS_LAT = 4;
  localparam int SCALE_LAT = 4;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int OUT_LAT   = 1;
  localparam int PIPE_LAT  = CROSS_LAT + SCALE_LAT + SQRT_LAT + DIV_LAT + OUT_LAT;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [2:0]       neg;
    logic             degen;
  } info_t;

  // Control plus the shifted magnitudes, needed again by the divider
  typedef struct packed {
    info_t                  info;
    logic [2:0][KEEP_W-1:0] sm;
  } side_t;

endpackage
`default_nettype wire

[src/triangle_face_normal.sv]
// Triangle face normal, top level: unit normal of b x a in Q1.14.
// Depends on tfn_pkg, tfn_cross, tfn_scale, tfn_sqrt, tfn_div.
//
// Usage:
//   Raise start with a face on the in_ ports; the transaction is taken at
//   the clock edge where start is high and busy is low. busy stays low, so
//   a new face may be presented every cycle.
//   Each face yields one result on the out_ ports, marked by out_valid for
//   exactly one cycle. Results leave in the order faces entered.
//   Throughput is one face per cycle: every stage is a register stage and
//   the root (31 stages) and the divider (1 + 15 stages) resolve one bit
//   per stage.
//   A face flagged too_few_vertices, or one whose cross product is zero,
//   returns a zero normal with out_degenerate set.
//   Synchronous reset clears all valid bits; faces in flight are dropped.
//   The receiver cannot stall the block; results must be taken when shown.
`default_nettype none
module triangle_face_normal #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tfn_pkg::TAG_W-1:0]     in_face_index,
  input  wire logic                          in_too_few_vertices,
  input  wire logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_p1_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_p2_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_p3_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p3_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_p3_z,
  output logic                               out_valid,
  output logic [tfn_pkg::TAG_W-1:0]          out_face_tag,
  output logic signed [tfn_pkg::OUT_W-1:0]   out_normal_x,
  output logic signed [tfn_pkg::OUT_W-1:0]   out_normal_y,
  output logic signed [tfn_pkg::OUT_W-1:0]   out_normal_z,
  output logic                               out_degenerate
);
  import tfn_pkg::*;

  localparam int MW = 2 * COORD_WIDTH + 3;

  logic                              accept;
  logic [2:0][2:0][COORD_WIDTH-1:0]  pos;
  logic                              cr_valid, sc_valid, sq_valid, dv_valid;
  info_t                             cr_info, dv_info;
  logic [2:0][MW-1:0]                cr_mag;
  side_t                             sc_side, sq_side;
  logic [SUM_W-1:0]                  sc_sum;
  logic [ROOT_W-1:0]                 sq_root;
  logic [2:0][Q_W-1:0]               dv_q;

  logic                              valid_r;
  logic [TAG_W-1:0]                  tag_r;
  logic [2:0][OUT_W-1:0]             nrm_nxt, nrm_r;
  logic                              degen_r;

  // pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign pos[0] = {in_p1_z, in_p1_y, in_p1_x};
  assign pos[1] = {in_p2_z, in_p2_y, in_p2_x};
  assign pos[2] = {in_p3_z, in_p3_y, in_p3_x};

  tfn_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_tag    (in_face_index),
    .in_short  (in_too_few_vertices),
    .in_pos    (pos),
    .out_valid (cr_valid),
    .out_info  (cr_info),
    .out_mag   (cr_mag)
  );

  tfn_scale #(.CW(COORD_WIDTH)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cr_valid),
    .in_info   (cr_info),
    .in_mag    (cr_mag),
    .out_valid (sc_valid),
    .out_side  (sc_side),
    .out_sum   (sc_sum)
  );

  tfn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_side   (sc_side),
    .in_sum    (sc_sum),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  tfn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_len    (sq_root),
    .out_valid (dv_valid),
    .out_info  (dv_info),
    .out_q     (dv_q)
  );

  // apply sign, zero degenerate faces
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_info.degen) begin
        nrm_nxt[j] = '0;
      end else if (dv_info.neg[j]) begin
        nrm_nxt[j] = OUT_W'(-OUT_W'(dv_q[j]));
      end else begin
        nrm_nxt[j] = OUT_W'(dv_q[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= dv_info.tag;
    nrm_r   <= nrm_nxt;
    degen_r <= dv_info.degen;
  end

  assign out_valid      = valid_r;
  assign out_face_tag   = tag_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = degen_r;

  // every result comes from a transaction taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result without matching transaction");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0))
    else $error("degenerate face with nonzero normal");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_normal_x != '0) || (out_normal_y != '0) || (out_normal_z != '0))
    else $error("valid face with zero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_normal_x <= OUT_W'(ONE_Q14)) && (out_normal_x >= -OUT_W'(ONE_Q14)) &&
      (out_normal_y <= OUT_W'(ONE_Q14)) && (out_normal_y >= -OUT_W'(ONE_Q14)) &&
      (out_normal_z <= OUT_W'(ONE_Q14)) && (out_normal_z >= -OUT_W'(ONE_Q14)))
    else $error("normal component out of Q1.14 range");

endmodule
`default_nettype wire

[src/tfn_cross.sv]
// Edge vectors, exact cross product and component magnitudes (4 stages).
// Depends on tfn_pkg.
`default_nettype none
module tfn_cross #(
  parameter int CW = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic [tfn_pkg::TAG_W-1:0]              in_tag,
  input  wire logic                                   in_short,
  input  wire logic [2:0][2:0][CW-1:0]                in_pos,
  output logic                                        out_valid,
  output tfn_pkg::info_t                              out_info,
  output logic [2:0][2*CW+2:0]                        out_mag
);
  import tfn_pkg::*;

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int MW = PW + 1;

  logic [CROSS_LAT-1:0]            v_r;
  logic [CROSS_LAT-1:0][TAG_W-1:0] tag_r;
  logic [CROSS_LAT-1:0]            short_r;

  logic signed [EW-1:0] ea_nxt [3];
  logic signed [EW-1:0] eb_nxt [3];
  logic signed [EW-1:0] ea_r   [3];
  logic signed [EW-1:0] eb_r   [3];
  logic signed [PW-1:0] prod_nxt [6];
  logic signed [PW-1:0] prod_r   [6];
  logic signed [MW-1:0] cr_nxt [3];
  logic signed [MW-1:0] cr_r   [3];
  logic [2:0]           neg_nxt, neg_r;
  logic [2:0][MW-1:0]   mag_nxt, mag_r;

  // control shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[CROSS_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= {tag_r[CROSS_LAT-2:0], in_tag};
    short_r <= {short_r[CROSS_LAT-2:0], in_short};
  end

  // stage 1: edges a = p1 - p2, b = p3 - p2
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ea_nxt[j] = EW'(signed'(in_pos[0][j])) - EW'(signed'(in_pos[1][j]));
      eb_nxt[j] = EW'(signed'(in_pos[2][j])) - EW'(signed'(in_pos[1][j]));
    end
  end

  // stage 2: six partial products of b x a
  always_comb begin
    prod_nxt[0] = PW'(eb_r[1]) * PW'(ea_r[2]);
    prod_nxt[1] = PW'(eb_r[2]) * PW'(ea_r[1]);
    prod_nxt[2] = PW'(eb_r[2]) * PW'(ea_r[0]);
    prod_nxt[3] = PW'(eb_r[0]) * PW'(ea_r[2]);
    prod_nxt[4] = PW'(eb_r[0]) * PW'(ea_r[1]);
    prod_nxt[5] = PW'(eb_r[1]) * PW'(ea_r[0]);
  end

  // stage 3: cross components; stage 4: sign and magnitude
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cr_nxt[j]  = MW'(prod_r[2*j]) - MW'(prod_r[2*j+1]);
      neg_nxt[j] = cr_r[j][MW-1];
      mag_nxt[j] = cr_r[j][MW-1] ? MW'(-cr_r[j]) : MW'(cr_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      ea_r[j] <= ea_nxt[j];
      eb_r[j] <= eb_nxt[j];
      cr_r[j] <= cr_nxt[j];
    end
    for (int k = 0; k < 6; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
  end

  assign out_valid      = v_r[CROSS_LAT-1];
  assign out_info.tag   = tag_r[CROSS_LAT-1];
  assign out_info.neg   = neg_r;
  assign out_info.degen = short_r[CROSS_LAT-1];
  assign out_mag        = mag_r;

endmodule
`default_nettype wire

[src/tfn_scale.sv]
// Common right shift to 30 bits, squares and sum of squares (4 stages).
// Depends on tfn_pkg.
`default_nettype none
module tfn_scale #(
  parameter int CW = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire tfn_pkg::info_t               in_info,
  input  wire logic [2:0][2*CW+2:0]         in_mag,
  output logic                              out_valid,
  output tfn_pkg::side_t                    out_side,
  output logic [tfn_pkg::SUM_W-1:0]         out_sum
);
  import tfn_pkg::*;

  localparam int MW   = 2 * CW + 3;
  localparam int SH_W = $clog2(MW + 1);

  logic [SCALE_LAT-1:0] v_r;
  logic [MW-1:0]        all_or;
  logic [SH_W-1:0]      top;
  logic [SH_W-1:0]      sh_nxt, sh_r;
  logic [2:0][MW-1:0]   mag5_r;
  info_t                info5_nxt, info5_r, info6_r, info7_r, info8_r;
  logic [2:0][KEEP_W-1:0] sm_nxt, sm6_r, sm7_r, sm8_r;
  logic [2:0][SQ_W-1:0] sq_r;
  logic [SUM_W-1:0]     sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[SCALE_LAT-2:0], in_valid};
    end
  end

  // stage 5: bit length of the largest magnitude sets the shift
  always_comb begin
    all_or = in_mag[0] | in_mag[1] | in_mag[2];
    top    = '0;
    for (int i = 0; i < MW; i++) begin
      if (all_or[i]) top = SH_W'(i + 1);
    end
    sh_nxt = (top > SH_W'(KEEP_W)) ? top - SH_W'(KEEP_W) : '0;
    info5_nxt       = in_info;
    info5_nxt.degen = in_info.degen | (all_or == '0);
  end

  // stage 6: truncating shift
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sm_nxt[j] = KEEP_W'(mag5_r[j] >> sh_r);
    end
  end

  always_ff @(posedge clk) begin
    mag5_r  <= in_mag;
    sh_r    <= sh_nxt;
    info5_r <= info5_nxt;
    sm6_r   <= sm_nxt;
    info6_r <= info5_r;
    // stage 7: squares
    for (int j = 0; j < 3; j++) begin
      sq_r[j] <= SQ_W'(sm6_r[j]) * SQ_W'(sm6_r[j]);
    end
    sm7_r   <= sm6_r;
    info7_r <= info6_r;
    // stage 8: sum of squares
    sum_r   <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    sm8_r   <= sm7_r;
    info8_r <= info7_r;
  end

  assign out_valid     = v_r[SCALE_LAT-1];
  assign out_side.info = info8_r;
  assign out_side.sm   = sm8_r;
  assign out_sum       = sum_r;

endmodule
`default_nettype wire

[src/tfn_sqrt.sv]
// Pipelined integer square root, one result bit per stage (31 stages).
// Depends on tfn_pkg.
`default_nettype none
module tfn_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire tfn_pkg::side_t                in_side,
  input  wire logic [tfn_pkg::SUM_W-1:0]     in_sum,
  output logic                               out_valid,
  output tfn_pkg::side_t                     out_side,
  output logic [tfn_pkg::ROOT_W-1:0]         out_root
);
  import tfn_pkg::*;

  logic             v_r    [ROOT_W+1];
  side_t            side_r [ROOT_W+1];
  logic [RES_W-1:0] rem_r  [ROOT_W+1];
  logic [RES_W-1:0] res_r  [ROOT_W+1];

  // index 0 is the stage input
  assign v_r[0]    = in_valid;
  assign side_r[0] = in_side;
  assign rem_r[0]  = RES_W'(in_sum);
  assign res_r[0]  = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam logic [RES_W-1:0] BITV = RES_W'(1) << (2 * (ROOT_W - 1 - g));
    logic [RES_W-1:0] trial;
    logic [RES_W-1:0] rem_nxt, res_nxt;

    // one digit of the restoring root
    always_comb begin
      trial = res_r[g] + BITV;
      if (rem_r[g] >= trial) begin
        rem_nxt = rem_r[g] - trial;
        res_nxt = (res_r[g] >> 1) + BITV;
      end else begin
        rem_nxt = rem_r[g];
        res_nxt = res_r[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      side_r[g+1] <= side_r[g];
      rem_r[g+1]  <= rem_nxt;
      res_r[g+1]  <= res_nxt;
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];
  assign out_root  = res_r[ROOT_W][ROOT_W-1:0];

endmodule
`default_nettype wire

[src/tfn_div.sv]
// Rounded division of each magnitude by the length, Q1.14 quotient.
// One quotient bit per stage, three lanes sharing the divisor. Depends on tfn_pkg.
`default_nettype none
module tfn_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire tfn_pkg::side_t                in_side,
  input  wire logic [tfn_pkg::ROOT_W-1:0]    in_len,
  output logic                               out_valid,
  output tfn_pkg::info_t                     out_info,
  output logic [2:0][tfn_pkg::Q_W-1:0]       out_q
);
  import tfn_pkg::*;

  logic                  v_r    [Q_W+1];
  info_t                 info_r [Q_W+1];
  logic [ROOT_W-1:0]     dvs_r  [Q_W+1];
  logic [2:0][NUM_W-1:0] num_r  [Q_W+1];
  logic [2:0][Q_W-1:0]   q_r    [Q_W+1];

  // entry stage: numerator m*16384 + floor(L/2)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    info_r[0] <= in_side.info;
    dvs_r[0]  <= in_len;
    for (int j = 0; j < 3; j++) begin
      num_r[0][j] <= (NUM_W'(in_side.sm[j]) << FRAC_Q) + NUM_W'(in_len >> 1);
    end
    q_r[0] <= '0;
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    localparam int QB = Q_W - 1 - g;
    logic [NUM_W-1:0]      dsh;
    logic [2:0][NUM_W-1:0] num_nxt;
    logic [2:0][Q_W-1:0]   q_nxt;

    // subtract the shifted divisor where it fits
    always_comb begin
      dsh     = NUM_W'(dvs_r[g]) << QB;
      num_nxt = num_r[g];
      q_nxt   = q_r[g];
      for (int j = 0; j < 3; j++) begin
        if (num_r[g][j] >= dsh) begin
          num_nxt[j]   = num_r[g][j] - dsh;
          q_nxt[j][QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      info_r[g+1] <= info_r[g];
      dvs_r[g+1]  <= dvs_r[g];
      num_r[g+1]  <= num_nxt;
      q_r[g+1]    <= q_nxt;
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_info  = info_r[Q_W];
  assign out_q     = q_r[Q_W];

endmodule
`default_nettype wire
